FILE: sv/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package u8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned CP_W = 21;
	localparam int unsigned PART_W = 15;
	localparam int unsigned REM_W = 2;

	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_CODE_POINT = 3'd0,
		KIND_BAD_LEAD   = 3'd1,
		KIND_BAD_CONT   = 3'd2,
		KIND_SURROGATE  = 3'd3,
		KIND_INCOMPLETE = 3'd4
	} kind_t;

	// One decode outcome for one byte.
	typedef struct packed {
		logic            valid;
		kind_t           kind;
		logic [CP_W-1:0] code_point;
	} result_t;

	// One registered request waiting for the decode step.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} req_t;

endpackage

FILE: sv/u8sd_in_reg.sv
// Input register stage that holds one byte request until the decoder takes it.
`timescale 1ns / 1ps
module u8sd_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_ready,
	input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
	input  logic                      end_of_text,
	input  logic                      advance,
	output u8sd_pkg::req_t            req_s1
);
	import u8sd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// The stage can load when it is empty or its content moves on this cycle.
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= end_of_text;
		end
	end

	assign req_s1 = '{valid: valid_s1, data: byte_s1, last: last_s1};

endmodule

FILE: sv/u8sd_decode.sv
// Sequence state and the combinational decode step for one byte.
`timescale 1ns / 1ps
module u8sd_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  u8sd_pkg::req_t   req_s1,
	output u8sd_pkg::result_t res
);
	import u8sd_pkg::*;

	logic [PART_W-1:0] partial_q;
	logic [REM_W-1:0]  remaining_q;
	logic [PART_W-1:0] partial_d;
	logic [REM_W-1:0]  remaining_d;
	logic [CP_W-1:0]   shifted;
	logic [BYTE_W-1:0] b;
	logic              emit;
	kind_t             kind;
	logic [CP_W-1:0]   cp;

	assign b = req_s1.data;
	assign shifted = {partial_q, b[5:0]};

	always_comb begin
		partial_d   = partial_q;
		remaining_d = remaining_q;
		emit        = 1'b0;
		kind        = KIND_CODE_POINT;
		cp          = '0;
		if (remaining_q == '0) begin
			if (!b[7]) begin
				emit = 1'b1;
				cp   = {{(CP_W-BYTE_W){1'b0}}, b};
			end else if (b[7:5] == 3'b110) begin
				remaining_d = 2'd1;
				partial_d   = {{(PART_W-5){1'b0}}, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				remaining_d = 2'd2;
				partial_d   = {{(PART_W-4){1'b0}}, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				remaining_d = 2'd3;
				partial_d   = {{(PART_W-3){1'b0}}, b[2:0]};
			end else begin
				emit        = 1'b1;
				kind        = KIND_BAD_LEAD;
				remaining_d = '0;
				partial_d   = '0;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				emit        = 1'b1;
				kind        = KIND_BAD_CONT;
				remaining_d = '0;
				partial_d   = '0;
			end else begin
				remaining_d = remaining_q - 2'd1;
				if (remaining_d == '0) begin
					partial_d = '0;
					emit      = 1'b1;
					if (shifted >= SURR_LO && shifted <= SURR_HI) begin
						kind = KIND_SURROGATE;
					end else begin
						cp = shifted;
					end
				end else begin
					partial_d = shifted[PART_W-1:0];
				end
			end
		end
		// A sequence left open by the last byte of a message is incomplete.
		if (!emit && req_s1.last) begin
			emit        = 1'b1;
			kind        = KIND_INCOMPLETE;
			remaining_d = '0;
			partial_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			remaining_q <= '0;
		end else if (advance) begin
			partial_q   <= partial_d;
			remaining_q <= remaining_d;
		end
	end

	assign res = '{valid: emit, kind: kind, code_point: cp};

endmodule

FILE: sv/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input stage, decode step and result register.
`timescale 1ns / 1ps
// A byte waits in the input stage; its outcome then goes to the result register.
// Throughput: one byte per cycle while results are taken; the input stage and the
// result register each hold one request, so a new byte is taken while a result waits.
// Bytes that complete no result (lead and middle bytes) leave no output.
// Reset (arst_n low) empties both stages and clears the sequence state.
module utf8_stream_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_ready,
	input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
	input  logic                        end_of_text,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [u8sd_pkg::KIND_W-1:0] result_kind,
	output logic [u8sd_pkg::CP_W-1:0]   code_point
);
	import u8sd_pkg::*;

	req_t            req_s1;
	result_t         res;
	logic            advance;
	logic            out_valid_q;
	kind_t           kind_q;
	logic [CP_W-1:0] cp_q;

	// The byte in the input stage is decoded when the result register can
	// take its outcome: either the register is empty or its request leaves
	// this cycle. The sequence state updates on the same edge.
	assign advance = req_s1.valid && (!out_valid_q || result_ready);

	u8sd_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.advance     (advance),
		.req_s1      (req_s1)
	);

	u8sd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.req_s1 (req_s1),
		.res    (res)
	);

	// Result register. A decoded byte with no outcome simply leaves it empty
	// once the previous result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q <= res.kind;
			cp_q   <= res.code_point;
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind  = kind_q;
	assign code_point   = cp_q;

endmodule
